/* rtl/hcbd_pkg.sv */
package hcbd_pkg;

	localparam logic [31:0] DEFAULT_BODY_LIMIT = 32'd65536;
	localparam logic [15:0] TRAILER_LIMIT      = 16'd512;
	localparam logic [3:0]  MAX_SIZE_DIGITS    = 4'd8;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_TAB  = 8'h09;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_DEL  = 8'h7F;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_EXT,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_TRAILER,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_PAYLOAD,
		ST_DONE,
		ST_MALFORMED,
		ST_TOOBIG
	} status_t;

	typedef enum logic {
		CMD_DATA,
		CMD_START
	} command_t;

	typedef struct packed {
		command_t    command;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  payload_byte;
		logic        consumed;
	} res_t;

endpackage

/* rtl/http_chunked_body_decoder.sv */
// channel   | handshake                | payload
// ----------+--------------------------+----------------------------------
// request   | req_valid / req_ready    | req_data   (command, data_byte)
// result    | res_valid / res_ready    | res_data   (status, payload_byte,
//           |                          |             consumed)
// config    | cfg_wr_en                | cfg_wr_data (body_limit)
//
// One request per cycle while req_ready is high; its result appears in the cycle after acceptance.
// The parser state and result register update in the same edge, so the
// single result register is the only stage between the two sides.
// req_ready is low only while a result is held and res_ready is low.
// arst_n clears the parser state, body_limit and the result valid flag.
module http_chunked_body_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  hcbd_pkg::req_t     req_data,
	output logic               res_valid,
	input  logic               res_ready,
	output hcbd_pkg::res_t     res_data,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);
	import hcbd_pkg::*;

	phase_t       phase_q, phase_d;
	logic         cr_q, cr_d;
	logic [3:0]   digits_q, digits_d;
	logic [31:0]  chunk_q, chunk_d;
	logic [31:0]  total_q, total_d;
	logic [15:0]  trailer_q, trailer_d;
	logic         err_big_q, err_big_d;
	logic [31:0]  body_limit_q;

	logic         accept;
	logic [31:0]  limit;
	logic [7:0]   c;
	logic         is_hex;
	logic [3:0]   hex_val;
	logic         field_ok;
	logic [31:0]  chunk_shift;
	res_t         res_d;

	assign req_ready = !res_valid || res_ready;
	assign accept    = req_valid && req_ready;
	assign limit     = (body_limit_q == '0) ? DEFAULT_BODY_LIMIT : body_limit_q;
	assign c         = req_data.data_byte;
	assign field_ok  = (c == CHAR_TAB) || ((c >= CHAR_SP) && (c != CHAR_DEL));
	assign chunk_shift = {chunk_q[27:0], hex_val};

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (c inside {["0":"9"]}) begin
			hex_val = 4'(c - 8'h30);
		end else if (c inside {["a":"f"]}) begin
			hex_val = 4'(c - 8'h57);
		end else if (c inside {["A":"F"]}) begin
			hex_val = 4'(c - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		cr_d      = cr_q;
		digits_d  = digits_q;
		chunk_d   = chunk_q;
		total_d   = total_q;
		trailer_d = trailer_q;
		err_big_d = err_big_q;
		res_d.status       = ST_OK;
		res_d.payload_byte = 8'd0;
		res_d.consumed     = 1'b0;

		if (req_data.command == CMD_START) begin
			phase_d   = PH_SIZE;
			cr_d      = 1'b0;
			digits_d  = '0;
			chunk_d   = '0;
			total_d   = '0;
			trailer_d = '0;
			err_big_d = 1'b0;
		end else begin
			case (phase_q)
				PH_SIZE, PH_EXT: begin
					if (c == CHAR_CR) begin
						cr_d = 1'b1;
						res_d.consumed = 1'b1;
					end else if (c == CHAR_LF) begin
						if (!cr_q || (phase_q == PH_SIZE && digits_q == '0)) begin
							phase_d = PH_ERROR;
							err_big_d = 1'b0;
							res_d.status = ST_MALFORMED;
						end else begin
							cr_d = 1'b0;
							digits_d = '0;
							phase_d = (chunk_q == '0) ? PH_TRAILER : PH_DATA;
							res_d.consumed = 1'b1;
						end
					end else if (phase_q == PH_EXT) begin
						if (cr_q || !field_ok) begin
							phase_d = PH_ERROR;
							err_big_d = 1'b0;
							res_d.status = ST_MALFORMED;
						end else begin
							res_d.consumed = 1'b1;
						end
					end else if (cr_q || (c == CHAR_SEMI && digits_q == '0) ||
						(c != CHAR_SEMI && !is_hex)) begin
						phase_d = PH_ERROR;
						err_big_d = 1'b0;
						res_d.status = ST_MALFORMED;
					end else if (c == CHAR_SEMI) begin
						phase_d = PH_EXT;
						res_d.consumed = 1'b1;
					end else if (digits_q >= MAX_SIZE_DIGITS || chunk_shift > limit) begin
						phase_d = PH_ERROR;
						err_big_d = 1'b1;
						res_d.status = ST_TOOBIG;
					end else begin
						chunk_d = chunk_shift;
						digits_d = digits_q + 4'd1;
						res_d.consumed = 1'b1;
					end
				end
				PH_DATA: begin
					if (total_q >= limit) begin
						phase_d = PH_ERROR;
						err_big_d = 1'b1;
						res_d.status = ST_TOOBIG;
					end else begin
						res_d.status = ST_PAYLOAD;
						res_d.payload_byte = c;
						res_d.consumed = 1'b1;
						total_d = total_q + 32'd1;
						chunk_d = chunk_q - 32'd1;
						if (chunk_q == 32'd1) begin
							phase_d = PH_DATA_CR;
						end
					end
				end
				PH_DATA_CR: begin
					if (c != CHAR_CR) begin
						phase_d = PH_ERROR;
						err_big_d = 1'b0;
						res_d.status = ST_MALFORMED;
					end else begin
						phase_d = PH_DATA_LF;
						res_d.consumed = 1'b1;
					end
				end
				PH_DATA_LF: begin
					if (c != CHAR_LF) begin
						phase_d = PH_ERROR;
						err_big_d = 1'b0;
						res_d.status = ST_MALFORMED;
					end else begin
						phase_d = PH_SIZE;
						chunk_d = '0;
						digits_d = '0;
						res_d.consumed = 1'b1;
					end
				end
				PH_TRAILER: begin
					// digits_q marks a non-empty trailer line here
					if (trailer_q >= TRAILER_LIMIT) begin
						phase_d = PH_ERROR;
						err_big_d = 1'b1;
						res_d.status = ST_TOOBIG;
					end else begin
						trailer_d = trailer_q + 16'd1;
						if (c == CHAR_CR) begin
							cr_d = 1'b1;
							res_d.consumed = 1'b1;
						end else if (c == CHAR_LF) begin
							if (!cr_q) begin
								phase_d = PH_ERROR;
								err_big_d = 1'b0;
								res_d.status = ST_MALFORMED;
							end else begin
								cr_d = 1'b0;
								res_d.consumed = 1'b1;
								if (digits_q == '0) begin
									phase_d = PH_DONE;
									res_d.status = ST_DONE;
								end else begin
									digits_d = '0;
								end
							end
						end else if (cr_q || !field_ok) begin
							phase_d = PH_ERROR;
							err_big_d = 1'b0;
							res_d.status = ST_MALFORMED;
						end else begin
							digits_d = 4'd1;
							res_d.consumed = 1'b1;
						end
					end
				end
				PH_DONE: begin
					res_d.status = ST_DONE;
				end
				default: begin
					res_d.status = err_big_q ? ST_TOOBIG : ST_MALFORMED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIZE;
			cr_q      <= 1'b0;
			digits_q  <= '0;
			chunk_q   <= '0;
			total_q   <= '0;
			trailer_q <= '0;
			err_big_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			cr_q      <= cr_d;
			digits_q  <= digits_d;
			chunk_q   <= chunk_d;
			total_q   <= total_d;
			trailer_q <= trailer_d;
			err_big_q <= err_big_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limit_q <= '0;
		end else if (cfg_wr_en) begin
			body_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (req_ready) begin
			res_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data <= res_d;
		end
	end

endmodule
